### sv/ghfe_pkg.sv
// ----------------------------------------------------------------------------
// ghfe_pkg
// shared types, constants and angle helpers of the gyro heading fix estimator
// ----------------------------------------------------------------------------
`default_nettype none

package ghfe_pkg;

  localparam int RingDepthDef   = 1024;
  localparam int FixDepthDef    = 16;
  localparam int CordicStepsDef = 16;
  localparam int CordicMax      = 24;

  localparam logic [10:0] MinFixDistRst = 11'd50;
  localparam logic [13:0] MaxHeadChgRst = 14'd1280;
  localparam logic [9:0]  MinSpeedRst   = 10'd100;

  localparam logic [1:0] CfgMinFixDist = 2'd0;
  localparam logic [1:0] CfgMaxHeadChg = 2'd1;
  localparam logic [1:0] CfgMinSpeed   = 2'd2;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpFix    = 2'd1,
    OpTarget = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StTickChk,
    StFixRd,
    StFixEnt,
    StFixChk,
    StFixMid,
    StCordic,
    StBearing,
    StUpdate,
    StResult
  } state_e;

  // wrap into one turn, valid for inputs within one and a half turns of zero
  function automatic logic signed [14:0] wrap_angle(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (v > 18'sd11519) begin
      r = v - 18'sd23040;
    end else if (v < -18'sd11520) begin
      r = v + 18'sd23040;
    end
    return r[14:0];
  endfunction

  // value / 10 rounded to nearest, ties away from zero
  function automatic logic signed [14:0] tenth(input logic signed [14:0] v);
    logic [14:0] mag;
    logic [15:0] n;
    logic [31:0] prod;
    logic [14:0] q;
    mag  = v[14] ? (~v + 15'd1) : v;
    n    = {1'b0, mag} + 16'd5;
    prod = {16'd0, n} * 32'd52429;
    q    = 15'(prod >> 19);
    return v[14] ? (~q + 15'd1) : q;
  endfunction

  // atan(2^-i) in 1/64 degree scaled by 2^16
  function automatic logic signed [31:0] atan_step(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd188743680;
      5'd1:  a = 32'sd111421900;
      5'd2:  a = 32'sd58872272;
      5'd3:  a = 32'sd29884485;
      5'd4:  a = 32'sd15000234;
      5'd5:  a = 32'sd7507429;
      5'd6:  a = 32'sd3754631;
      5'd7:  a = 32'sd1877430;
      5'd8:  a = 32'sd938729;
      5'd9:  a = 32'sd469366;
      5'd10: a = 32'sd234683;
      5'd11: a = 32'sd117342;
      5'd12: a = 32'sd58671;
      5'd13: a = 32'sd29335;
      5'd14: a = 32'sd14668;
      5'd15: a = 32'sd7334;
      5'd16: a = 32'sd3667;
      5'd17: a = 32'sd1833;
      5'd18: a = 32'sd917;
      5'd19: a = 32'sd458;
      5'd20: a = 32'sd229;
      5'd21: a = 32'sd115;
      5'd22: a = 32'sd57;
      5'd23: a = 32'sd29;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### sv/gyro_heading_fix_estimator_unit.sv
// ----------------------------------------------------------------------------
// gyro_heading_fix_estimator_unit
// heading ring and fix queue in synchronous memories, bearing search with a
// one-step-per-cycle cordic, absolute heading offset estimation
// ----------------------------------------------------------------------------
// sequence: tick checks the oldest fix, then result; set target and clear go straight to
//   result; a position fix reads queue then ring per older fix examined, and a bearing
//   adds midpoint, cordic (skipped when both fixes share a position), bearing and update
// throughput: one beat at a time; the fix search is bound by the queue read,
//   then ring read per entry, and by the iterations of the cordic unit
// reset: control state cleared at once, ring slot zero marked cleared by a
//   flag, no clearing pass
`default_nettype none

module gyro_heading_fix_estimator_unit #(
  parameter int RING_DEPTH   = ghfe_pkg::RingDepthDef,
  parameter int FIX_DEPTH    = ghfe_pkg::FixDepthDef,
  parameter int CORDIC_STEPS = ghfe_pkg::CordicStepsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // gyro_step, pos_x, pos_y, drive_speed, target_angle, target_absolute
  input  wire logic [63:0] s_axis_tdata,
  // op
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // heading_error, heading_abs, abs_valid
  output      logic [31:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [13:0] cfg_data_i
);

  localparam int RW   = $clog2(RING_DEPTH);
  localparam int QW   = $clog2(FIX_DEPTH);
  localparam int CNTW = $clog2(FIX_DEPTH + 1);
  localparam int CIW  = $clog2(CORDIC_STEPS);
  localparam int EW   = RW + 31;
  localparam int XW   = 30;

  // input fields
  logic [1:0]         in_op;
  logic signed [11:0] in_step;
  logic [9:0]         in_x, in_y;
  logic signed [10:0] in_spd;
  logic signed [14:0] in_tgt;
  logic               in_tabs;

  assign in_op   = s_axis_tuser;
  assign in_step = s_axis_tdata[11:0];
  assign in_x    = s_axis_tdata[21:12];
  assign in_y    = s_axis_tdata[31:22];
  assign in_spd  = s_axis_tdata[42:32];
  assign in_tgt  = s_axis_tdata[57:43];
  assign in_tabs = s_axis_tdata[58];

  ghfe_pkg::state_e state_q, state_d;

  logic [RW-1:0]      ptr_q, ptr_d;
  logic signed [14:0] cur_q, cur_d;
  logic               slot0_vld_q, slot0_vld_d;
  logic [QW-1:0]      front_q, front_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic signed [14:0] offset_q, offset_d;
  logic               off_set_q, off_set_d;
  logic signed [14:0] target_q, target_d;
  logic               tabs_q, tabs_d;
  logic [10:0]        min_dist_q;
  logic [13:0]        max_head_q;
  logic [9:0]         min_spd_q;
  logic               out_valid_q, out_valid_d;

  logic [QW-1:0]      pn_q, pn_d;
  logic [QW-1:0]      newest_q, newest_d;
  logic [9:0]         fx_q, fx_d, fy_q, fy_d;
  logic signed [10:0] fspd_q, fspd_d;
  logic [EW-1:0]      ent_q, ent_d;
  logic signed [14:0] hmid_q, hmid_d;
  logic signed [XW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [31:0] cz_q, cz_d;
  logic [CIW-1:0]     ci_q, ci_d;
  logic signed [14:0] diff_q, diff_d;
  logic [31:0]        out_data_q, out_data_d;

  // memories
  logic [14:0]   ring_mem [RING_DEPTH];
  logic          ring_we;
  logic [RW-1:0] ring_waddr, ring_raddr;
  logic [14:0]   ring_wdata, ring_rdata_q;
  logic          ring_rzero_q;
  logic signed [14:0] ring_rd;

  logic [EW-1:0] q_mem [FIX_DEPTH];
  logic          q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  logic [EW-1:0] q_wdata, q_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rdata_q <= ring_mem[ring_raddr];
    ring_rzero_q <= (ring_raddr == '0) && !slot0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= q_mem[q_raddr];
  end

  assign ring_rd = ring_rzero_q ? 15'sd0 : $signed(ring_rdata_q);

  // entry fields
  logic [9:0]         e_x, e_y;
  logic signed [10:0] e_spd;
  logic [RW-1:0]      e_slot, rd_slot;

  assign e_x     = ent_q[9:0];
  assign e_y     = ent_q[19:10];
  assign e_spd   = ent_q[30:20];
  assign e_slot  = ent_q[EW-1:31];
  assign rd_slot = q_rdata_q[EW-1:31];

  // difference between the new fix and the entry
  logic signed [10:0] dx, dy;
  logic [10:0]        fix_dist;
  assign dx       = $signed({1'b0, fx_q}) - $signed({1'b0, e_x});
  assign dy       = $signed({1'b0, fy_q}) - $signed({1'b0, e_y});
  assign fix_dist = (dx[10] ? 11'(-dx) : 11'(dx)) + (dy[10] ? 11'(-dy) : 11'(dy));

  always_comb begin
    logic [RW-1:0]      ptr_n;
    logic [CNTW:0]      qsum;
    logic [QW-1:0]      qp;
    logic [CNTW-1:0]    cnt_n;
    logic [QW:0]        isum;
    logic signed [14:0] dh;
    logic [RW:0]        dd, sm;
    logic signed [XW-1:0] xs, ys;
    logic signed [32:0] rr;
    logic signed [14:0] brg;
    logic signed [11:0] lim, so, sn;
    logic               c_rev, c_fwd;
    logic signed [14:0] tv;
    logic signed [17:0] cur_tgt;
    logic signed [14:0] err, habs;

    state_d     = state_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    slot0_vld_d = slot0_vld_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    offset_d    = offset_q;
    off_set_d   = off_set_q;
    target_d    = target_q;
    tabs_d      = tabs_q;
    out_valid_d = out_valid_q;
    pn_d        = pn_q;
    newest_d    = newest_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    fspd_d      = fspd_q;
    ent_d       = ent_q;
    hmid_d      = hmid_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    ci_d        = ci_q;
    diff_d      = diff_q;
    out_data_d  = out_data_q;
    ring_we     = 1'b0;
    ring_waddr  = ptr_q;
    ring_wdata  = '0;
    ring_raddr  = ptr_q;
    q_we        = 1'b0;
    q_waddr     = front_q;
    q_wdata     = '0;
    q_raddr     = front_q;
    s_axis_tready = 1'b0;

    ptr_n = (ptr_q == RW'(RING_DEPTH - 1)) ? '0 : ptr_q + RW'(1);
    qsum  = {1'b0, CNTW'(front_q)} + {1'b0, cnt_q};
    if (qsum >= (CNTW + 1)'(FIX_DEPTH)) begin
      qsum = qsum - (CNTW + 1)'(FIX_DEPTH);
    end
    qp    = QW'(qsum);
    cnt_n = cnt_q;
    isum  = {1'b0, front_q} + {1'b0, pn_q};
    if (isum >= (QW + 1)'(FIX_DEPTH)) begin
      isum = isum - (QW + 1)'(FIX_DEPTH);
    end
    dh = ghfe_pkg::wrap_angle(18'(cur_q) - 18'(ring_rd));
    if (ptr_q >= e_slot) begin
      dd = {1'b0, ptr_q} - {1'b0, e_slot};
    end else begin
      dd = {1'b0, ptr_q} + (RW + 1)'(RING_DEPTH) - {1'b0, e_slot};
    end
    sm = (dd >> 1) + {1'b0, e_slot};
    if (sm >= (RW + 1)'(RING_DEPTH)) begin
      sm = sm - (RW + 1)'(RING_DEPTH);
    end
    xs  = cx_q >>> ci_q;
    ys  = cy_q >>> ci_q;
    rr  = 33'(cz_q) + 33'sd32768;
    brg = ghfe_pkg::wrap_angle(18'($signed(rr[32:16])));
    lim = $signed({2'b00, min_spd_q});
    so  = 12'(e_spd);
    sn  = 12'(fspd_q);
    c_rev = (so < -lim) && (sn < -lim) && ((diff_q > 15'sd5760) || (diff_q < -15'sd5760));
    c_fwd = (so > lim) && (sn > lim);
    tv  = c_rev ? ghfe_pkg::wrap_angle(18'(diff_q) - 18'sd11520) : diff_q;
    cur_tgt = 18'(cur_q) + (tabs_q ? 18'(offset_q) : 18'sd0);
    err  = ghfe_pkg::wrap_angle(18'(target_q) - cur_tgt);
    habs = ghfe_pkg::wrap_angle(18'(cur_q) + 18'(offset_q));

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ghfe_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ghfe_pkg::StResult;
          case (in_op)
            ghfe_pkg::OpTick: begin
              cur_d      = ghfe_pkg::wrap_angle(18'(cur_q) + 18'(in_step));
              ptr_d      = ptr_n;
              ring_we    = 1'b1;
              ring_waddr = ptr_n;
              ring_wdata = cur_d;
              if (ptr_n == '0) begin
                slot0_vld_d = 1'b1;
              end
              q_raddr = front_q;
              state_d = ghfe_pkg::StTickChk;
            end
            ghfe_pkg::OpFix: begin
              q_we     = 1'b1;
              q_waddr  = qp;
              q_wdata  = {ptr_q, in_spd, in_y, in_x};
              fx_d     = in_x;
              fy_d     = in_y;
              fspd_d   = in_spd;
              newest_d = qp;
              if (cnt_q == CNTW'(FIX_DEPTH)) begin
                front_d = (front_q == QW'(FIX_DEPTH - 1)) ? '0 : front_q + QW'(1);
              end else begin
                cnt_n = cnt_q + CNTW'(1);
              end
              cnt_d = cnt_n;
              if (cnt_n >= CNTW'(2)) begin
                pn_d    = QW'(cnt_n - CNTW'(2));
                state_d = ghfe_pkg::StFixRd;
              end
            end
            ghfe_pkg::OpTarget: begin
              tabs_d = in_tabs;
              if (in_tabs) begin
                target_d = ghfe_pkg::wrap_angle(18'(in_tgt));
              end else begin
                target_d = ghfe_pkg::wrap_angle(18'(in_tgt) + 18'(cur_q));
              end
            end
            default: begin
              ptr_d       = '0;
              cur_d       = '0;
              ring_we     = 1'b1;
              ring_waddr  = '0;
              ring_wdata  = '0;
              slot0_vld_d = 1'b1;
              cnt_d       = '0;
              offset_d    = '0;
              off_set_d   = 1'b0;
            end
          endcase
        end
      end
      ghfe_pkg::StTickChk: begin
        if ((cnt_q != '0) && (rd_slot == ptr_q)) begin
          front_d = (front_q == QW'(FIX_DEPTH - 1)) ? '0 : front_q + QW'(1);
          cnt_d   = cnt_q - CNTW'(1);
        end
        state_d = ghfe_pkg::StResult;
      end
      ghfe_pkg::StFixRd: begin
        q_raddr = QW'(isum);
        state_d = ghfe_pkg::StFixEnt;
      end
      ghfe_pkg::StFixEnt: begin
        ent_d      = q_rdata_q;
        ring_raddr = rd_slot;
        state_d    = ghfe_pkg::StFixChk;
      end
      ghfe_pkg::StFixChk: begin
        if ((fix_dist < min_dist_q) ||
            ((dh[14] ? 15'(-dh) : 15'(dh)) >= {1'b0, max_head_q})) begin
          if (pn_q == '0) begin
            state_d = ghfe_pkg::StResult;
          end else begin
            pn_d    = pn_q - QW'(1);
            state_d = ghfe_pkg::StFixRd;
          end
        end else begin
          ring_raddr = RW'(sm);
          state_d    = ghfe_pkg::StFixMid;
        end
      end
      ghfe_pkg::StFixMid: begin
        hmid_d = ring_rd;
        ci_d   = '0;
        if (dy < 0) begin
          cx_d = -(XW'(dy) <<< 16);
          cy_d = -(XW'(dx) <<< 16);
          cz_d = (dx >= 0) ? 32'sd754974720 : -32'sd754974720;
        end else begin
          cx_d = XW'(dy) <<< 16;
          cy_d = XW'(dx) <<< 16;
          cz_d = '0;
        end
        if ((dx == 0) && (dy == 0)) begin
          cz_d    = '0;
          state_d = ghfe_pkg::StBearing;
        end else begin
          state_d = ghfe_pkg::StCordic;
        end
      end
      ghfe_pkg::StCordic: begin
        if (cy_q > 0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + ghfe_pkg::atan_step(5'(ci_q));
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - ghfe_pkg::atan_step(5'(ci_q));
        end
        ci_d = ci_q + CIW'(1);
        if (ci_q == CIW'(CORDIC_STEPS - 1)) begin
          state_d = ghfe_pkg::StBearing;
        end
      end
      ghfe_pkg::StBearing: begin
        diff_d  = ghfe_pkg::wrap_angle(18'(brg) - (18'(hmid_q) + 18'(offset_q)));
        state_d = ghfe_pkg::StUpdate;
      end
      ghfe_pkg::StUpdate: begin
        if (!off_set_q) begin
          offset_d = diff_q;
        end else if (c_rev || c_fwd) begin
          offset_d = ghfe_pkg::wrap_angle(18'(offset_q) + 18'(ghfe_pkg::tenth(tv)));
        end
        off_set_d = 1'b1;
        front_d   = newest_q;
        cnt_d     = CNTW'(1);
        state_d   = ghfe_pkg::StResult;
      end
      ghfe_pkg::StResult: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {1'b0, off_set_q, habs, err};
          out_valid_d = 1'b1;
          state_d     = ghfe_pkg::StIdle;
        end
      end
      default: begin
        state_d = ghfe_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghfe_pkg::StIdle;
      ptr_q       <= '0;
      cur_q       <= '0;
      slot0_vld_q <= 1'b0;
      front_q     <= '0;
      cnt_q       <= '0;
      offset_q    <= '0;
      off_set_q   <= 1'b0;
      target_q    <= '0;
      tabs_q      <= 1'b0;
      out_valid_q <= 1'b0;
      min_dist_q  <= ghfe_pkg::MinFixDistRst;
      max_head_q  <= ghfe_pkg::MaxHeadChgRst;
      min_spd_q   <= ghfe_pkg::MinSpeedRst;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cur_q       <= cur_d;
      slot0_vld_q <= slot0_vld_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      offset_q    <= offset_d;
      off_set_q   <= off_set_d;
      target_q    <= target_d;
      tabs_q      <= tabs_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ghfe_pkg::CfgMinFixDist: min_dist_q <= cfg_data_i[10:0];
          ghfe_pkg::CfgMaxHeadChg: max_head_q <= cfg_data_i;
          ghfe_pkg::CfgMinSpeed:   min_spd_q  <= cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pn_q       <= pn_d;
    newest_q   <= newest_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    fspd_q     <= fspd_d;
    ent_q      <= ent_d;
    hmid_q     <= hmid_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    ci_q       <= ci_d;
    diff_q     <= diff_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gyro heading fix estimator: a directed table of beats
// then random phases over several register settings, every result beat checked
// field by field against its typed row or an in-bench heading and bearing predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int RingN  = 1024;
  localparam int FixN   = 16;
  localparam int Steps  = 16;
  localparam int Limit  = 1500000;
  localparam int Settle = 120;

  typedef struct {
    ghfe_pkg::op_e   op;
    int              step;
    int              px;
    int              py;
    int              spd;
    int              tgt;
    bit              tabs;
  } cmd_t;

  typedef struct {
    logic [14:0] err;
    logic [14:0] habs;
    logic        av;
  } hdg_t;

  typedef struct {
    cmd_t cmd;
    bit   typed;
    hdg_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  // predictor state
  int     ring [RingN];
  int     rptr;
  int     fq_x [FixN];
  int     fq_y [FixN];
  int     fq_s [FixN];
  int     fq_slot [FixN];
  int     qfront;
  int     qcount;
  int     offs;
  bit     offs_set;
  int     tgt_hdg;
  bit     tgt_abs;
  int     min_dist;
  int     max_chg;
  int     min_spd;

  hdg_t   exp_hdg [$];
  int     n_err = 0;
  int     cyc = 0;
  bit     calm = 1'b0;
  logic   hold = 1'b0;
  bit     hold_go = 1'b0;

  gyro_heading_fix_estimator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  function automatic int wrapa(int v);
    int r;
    r = (v + 11520) % 23040;
    if (r < 0) r += 23040;
    return r - 11520;
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int tenth_round(int v);
    int q;
    q = (iabs(v) + 5) / 10;
    return v < 0 ? -q : q;
  endfunction

  function automatic int cordic_bearing(int a, int b);
    longint x, y, z, xs, ys;
    if (a == 0 && b == 0) return 0;
    x = longint'(b) * 65536;
    y = longint'(a) * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0 ? 64'sd11520 : -64'sd11520) * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(ghfe_pkg::atan_step(5'(i)));
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(ghfe_pkg::atan_step(5'(i)));
      end
    end
    return wrapa(int'((z + 32768) >>> 16));
  endfunction

  task automatic take_fix(int px, int py, int spd);
    int p, nw, cur, so, sn, s, fix_dist, dh, mid, diff;
    p = (qfront + qcount) % FixN;
    cur = ring[rptr];
    fq_x[p] = px;
    fq_y[p] = py;
    fq_s[p] = spd;
    fq_slot[p] = rptr;
    qcount++;
    if (qcount > FixN) begin
      qfront = (qfront + 1) % FixN;
      qcount--;
    end
    nw = (qfront + qcount - 1) % FixN;
    for (int pn = qcount - 2; pn >= 0; pn--) begin
      p = (qfront + pn) % FixN;
      s = fq_slot[p];
      fix_dist = iabs(px - fq_x[p]) + iabs(py - fq_y[p]);
      dh = wrapa(cur - ring[s]);
      if (fix_dist < min_dist || iabs(dh) >= max_chg) continue;
      mid = (((RingN + rptr - s) % RingN) / 2 + s) % RingN;
      diff = wrapa(cordic_bearing(px - fq_x[p], py - fq_y[p]) - (ring[mid] + offs));
      so = fq_s[p];
      sn = fq_s[nw];
      if (!offs_set) begin
        offs = diff;
      end else begin
        if (so < -min_spd && sn < -min_spd && iabs(diff) > 5760)
          offs += tenth_round(wrapa(diff - 11520));
        if (so > min_spd && sn > min_spd) offs += tenth_round(diff);
      end
      offs = wrapa(offs);
      offs_set = 1'b1;
      qfront = (qfront + qcount - 1) % FixN;
      qcount = 1;
      break;
    end
  endtask

  task automatic predict_heading(input cmd_t c, output hdg_t h);
    int cur;
    case (c.op)
      ghfe_pkg::OpTick: begin
        cur = ring[rptr] + c.step;
        rptr = (rptr + 1) % RingN;
        ring[rptr] = wrapa(cur);
        if (qcount != 0 && fq_slot[qfront] == rptr) begin
          qfront = (qfront + 1) % FixN;
          qcount--;
        end
      end
      ghfe_pkg::OpFix: take_fix(c.px, c.py, c.spd);
      ghfe_pkg::OpTarget: begin
        tgt_abs = c.tabs;
        tgt_hdg = c.tabs ? wrapa(c.tgt) : wrapa(c.tgt + ring[rptr]);
      end
      default: begin
        rptr = 0;
        ring[0] = 0;
        qcount = 0;
        offs = 0;
        offs_set = 1'b0;
      end
    endcase
    cur = ring[rptr] + (tgt_abs ? offs : 0);
    h.err = 15'(wrapa(tgt_hdg - cur));
    h.habs = 15'(wrapa(ring[rptr] + offs));
    h.av = offs_set;
  endtask

  task automatic report(string what, int got, int want);
    n_err++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
  endtask

  // drive one beat, then fold it into the predictor once accepted
  task automatic send_beat(cmd_t c, bit typed = 1'b0, hdg_t want = '{0, 0, 0});
    hdg_t h;
    while (!calm && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.op;
    s_axis_tdata <= {5'd0, c.tabs, 15'(c.tgt), 11'(c.spd), 10'(c.py), 10'(c.px), 12'(c.step)};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_heading(c, h);
    exp_hdg.push_back(typed ? want : h);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (exp_hdg.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 14'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ghfe_pkg::CfgMinFixDist: min_dist = val;
      ghfe_pkg::CfgMaxHeadChg: max_chg = val;
      default: min_spd = val;
    endcase
  endtask

  task automatic set_regs(int d, int hc, int sp);
    drain();
    write_reg(ghfe_pkg::CfgMinFixDist, d);
    write_reg(ghfe_pkg::CfgMaxHeadChg, hc);
    write_reg(ghfe_pkg::CfgMinSpeed, sp);
    @(posedge clk_i);
  endtask

  function automatic cmd_t mk(ghfe_pkg::op_e op, int step = 0, int px = 0, int py = 0,
                              int spd = 0, int tgt = 0, bit tabs = 0);
    cmd_t c;
    c.op = op;
    c.step = step;
    c.px = px;
    c.py = py;
    c.spd = spd;
    c.tgt = tgt;
    c.tabs = tabs;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int fix_pct);
    cmd_t c;
    int r;
    int mag;
    r = $urandom_range(0, 99);
    c = mk(ghfe_pkg::OpTick);
    c.px = $urandom_range(0, 1023);
    c.py = $urandom_range(0, 1023);
    mag = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(80, 700);
    c.spd = $urandom_range(0, 1) ? mag : -mag - $urandom_range(0, 1);
    c.tgt = $urandom_range(0, 23039) - 11520;
    c.tabs = $urandom_range(0, 1);
    c.step = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) - 2048
                                          : $urandom_range(0, 80) - 40;
    if (r < fix_pct) c.op = ghfe_pkg::OpFix;
    else if (r < fix_pct + 6) c.op = ghfe_pkg::OpTarget;
    else if (r < fix_pct + 8) c.op = ghfe_pkg::OpClear;
    return c;
  endfunction

  row_t dir_rows [] = '{
    '{mk(ghfe_pkg::OpTick, 0), 1, '{15'sd0, 15'sd0, 1'b0}},
    '{mk(ghfe_pkg::OpTick, 2047), 1, '{-15'sd2047, 15'sd2047, 1'b0}},
    '{mk(ghfe_pkg::OpTick, -2048), 1, '{15'sd1, -15'sd1, 1'b0}},
    '{mk(ghfe_pkg::OpTarget, 0, 0, 0, 0, 11519, 1), 1, '{-15'sd11520, -15'sd1, 1'b0}},
    '{mk(ghfe_pkg::OpTarget, 0, 0, 0, 0, -11520, 0), 1, '{-15'sd11520, -15'sd1, 1'b0}},
    '{mk(ghfe_pkg::OpClear), 1, '{15'sd11519, 15'sd0, 1'b0}},
    '{mk(ghfe_pkg::OpFix, 0, 0, 0, 1023), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, 7), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, -3), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpFix, 0, 500, 0, 200), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, 5), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpFix, 0, 1023, 1023, 300), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, -9), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpFix, 0, 900, 900, -1024), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, 2), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpFix, 0, 100, 100, -300), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, 1), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpFix, 0, 0, 1023, -150), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTarget, 0, 0, 0, 0, 4000, 0), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTarget, 0, 0, 0, 0, -4000, 1), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpTick, 11), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpFix, 0, 1023, 0, 50), 0, '{0, 0, 0}},
    '{mk(ghfe_pkg::OpClear), 0, '{0, 0, 0}}
  };

  // result checker
  initial begin
    hdg_t w;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_hdg.size() == 0) begin
          report("unexpected beat", int'(m_axis_tdata), 0);
        end else begin
          w = exp_hdg.pop_front();
          if (m_axis_tdata[14:0] !== w.err)
            report("heading_error", $signed(m_axis_tdata[14:0]), $signed(w.err));
          if (m_axis_tdata[29:15] !== w.habs)
            report("heading_abs", $signed(m_axis_tdata[29:15]), $signed(w.habs));
          if (m_axis_tdata[30] !== w.av)
            report("abs_valid", m_axis_tdata[30], w.av);
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !hold && (calm || $urandom_range(0, 99) >= 37);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold <= 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > Limit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    for (int i = 0; i < RingN; i++) ring[i] = 0;
    rptr = 0;
    qfront = 0;
    qcount = 0;
    offs = 0;
    offs_set = 1'b0;
    tgt_hdg = 0;
    tgt_abs = 1'b0;
    min_dist = int'(ghfe_pkg::MinFixDistRst);
    max_chg = int'(ghfe_pkg::MaxHeadChgRst);
    min_spd = int'(ghfe_pkg::MinSpeedRst);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

    // default registers, long receiver hold-off part way through
    for (int i = 0; i < 500; i++) begin
      if (i == 150) hold_go = 1'b1;
      send_beat(rand_cmd(22));
    end

    // loosest setting, no idling on either side
    set_regs(0, 11520, 0);
    calm = 1'b1;
    send_beat(mk(ghfe_pkg::OpFix, 0, 300, 300, 5));
    send_beat(mk(ghfe_pkg::OpFix, 0, 300, 300, 9));
    for (int i = 0; i < 300; i++) send_beat(rand_cmd(30));
    calm = 1'b0;

    // strictest setting: nothing matches, queue overflows
    set_regs(2047, 0, 1023);
    for (int i = 0; i < 40; i++) send_beat(rand_cmd(75));

    // fix left behind until its ring slot is rewritten
    set_regs(20, 2000, 500);
    send_beat(mk(ghfe_pkg::OpClear));
    send_beat(mk(ghfe_pkg::OpFix, 0, 10, 10, 600));
    for (int i = 0; i < 1030; i++) begin
      c = rand_cmd(0);
      c.op = ghfe_pkg::OpTick;
      send_beat(c);
    end
    for (int i = 0; i < 60; i++) send_beat(rand_cmd(35));

    set_regs(int'(ghfe_pkg::MinFixDistRst), int'(ghfe_pkg::MaxHeadChgRst),
             int'(ghfe_pkg::MinSpeedRst));
    for (int i = 0; i < 40; i++) send_beat(rand_cmd(25));

    drain();
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
sv/ghfe_pkg.sv
sv/gyro_heading_fix_estimator_unit.sv
verif/tb.sv
